@@ sv/pcpa_pkg.sv @@
// Shared types, codes and defaults for the per-CPU page allocator.
`default_nettype none
package pcpa_pkg;

  localparam int DEF_NUM_CPUS  = 8;
  localparam int DEF_NUM_PAGES = 1024;

  localparam int PAGE_W    = 10;
  localparam int LIMIT_W   = 11;
  localparam int CPU_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_LOWEST = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  localparam logic [PAGE_W-1:0]  LOWEST_RST = '0;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 11'd1024;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC = 2'd0,
    ST_FREED = 2'd1,
    ST_OOM   = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  lowest_page;
    logic [LIMIT_W-1:0] page_limit;
  } cfg_regs_t;

endpackage
`default_nettype wire

@@ sv/pcpa_ram.sv @@
// Single-port-write, single-port-read synchronous memory with registered read data.
`default_nettype none
module pcpa_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ sv/pcpa_cfg.sv @@
// APB register file holding the free-range bounds.
`default_nettype none
module pcpa_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [pcpa_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [pcpa_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic      [pcpa_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready,
  output pcpa_pkg::cfg_regs_t                      regs
);

  localparam int DW = pcpa_pkg::APB_DATA_W;

  logic [pcpa_pkg::PAGE_W-1:0]  lowest_r;
  logic [pcpa_pkg::LIMIT_W-1:0] limit_r;
  logic                         wr_en;

  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r <= pcpa_pkg::LOWEST_RST;
      limit_r  <= pcpa_pkg::LIMIT_RST;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        pcpa_pkg::REG_LOWEST: lowest_r <= cfg_pwdata[pcpa_pkg::PAGE_W-1:0];
        pcpa_pkg::REG_LIMIT:  limit_r  <= cfg_pwdata[pcpa_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      pcpa_pkg::REG_LOWEST: cfg_prdata = DW'(lowest_r);
      pcpa_pkg::REG_LIMIT:  cfg_prdata = DW'(limit_r);
      default:              cfg_prdata = '0;
    endcase
  end

  assign cfg_pready       = 1'b1;
  assign regs.lowest_page = lowest_r;
  assign regs.page_limit  = limit_r;

endmodule
`default_nettype wire

@@ sv/pcpa_seq.sv @@
// Request sequencer: read-modify-write of list heads and next links, steal walk, result register.
`default_nettype none
module pcpa_seq #(
  parameter int NUM_CPUS  = pcpa_pkg::DEF_NUM_CPUS,
  parameter int NUM_PAGES = pcpa_pkg::DEF_NUM_PAGES,
  parameter int CW        = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1,
  parameter int AW        = $clog2(NUM_PAGES),
  parameter int PW        = $clog2(NUM_PAGES + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pcpa_pkg::cfg_regs_t               cfg,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_command,
  input  wire logic [pcpa_pkg::CPU_W-1:0]        in_cpu,
  input  wire logic [pcpa_pkg::PAGE_W-1:0]       in_page,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [pcpa_pkg::STATUS_W-1:0]     out_status,
  output logic      [pcpa_pkg::PAGE_W-1:0]       out_granted_page,
  output logic                                   head_we,
  output logic      [CW-1:0]                     head_waddr,
  output logic      [PW-1:0]                     head_wdata,
  output logic                                   head_re,
  output logic      [CW-1:0]                     head_raddr,
  input  wire logic [PW-1:0]                     head_rdata,
  output logic                                   link_we,
  output logic      [AW-1:0]                     link_waddr,
  output logic      [PW-1:0]                     link_wdata,
  output logic                                   link_re,
  output logic      [AW-1:0]                     link_raddr,
  input  wire logic [PW-1:0]                     link_rdata
);

  localparam int CFW = pcpa_pkg::CPU_W;
  localparam int PGW = pcpa_pkg::PAGE_W;
  localparam logic [PW-1:0] END_MARK = PW'(NUM_PAGES);
  localparam logic [CW-1:0] LAST_CPU = CW'(NUM_CPUS - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FREE  = 9'b000000010,
    S_AHEAD = 9'b000000100,
    S_APOP  = 9'b000001000,
    S_SCAN  = 9'b000010000,
    S_CNT   = 9'b000100000,
    S_WALK  = 9'b001000000,
    S_GIVE  = 9'b010000000,
    S_WAIT  = 9'b100000000
  } seq_state_t;

  seq_state_t           state_r, state_nxt;
  logic [CW-1:0]        c_r, c_nxt;
  logic [PGW-1:0]       pg_r, pg_nxt;
  logic [CW-1:0]        v_r, v_nxt;
  logic [CW-1:0]        left_r, left_nxt;
  logic [PW-1:0]        h_r, h_nxt;
  logic [PW-1:0]        lh_r, lh_nxt;
  logic [PW-1:0]        last_r, last_nxt;
  logic [PW-1:0]        n_r, n_nxt;
  logic [PW-1:0]        k_r, k_nxt;
  logic [NUM_CPUS-1:0]  hvld_r, hvld_nxt;
  logic                 hrd_vld_r;
  logic                 out_valid_r, out_valid_nxt;
  pcpa_pkg::status_t    out_status_r, out_status_nxt;
  logic [PGW-1:0]       out_page_r, out_page_nxt;
  pcpa_pkg::status_t    res_status_r, res_status_nxt;
  logic [PGW-1:0]       res_page_r, res_page_nxt;

  logic                 in_accept;
  logic                 out_free;
  logic [CW-1:0]        cmod;
  logic                 bad_page;
  logic [PW-1:0]        hd;
  logic                 fin;
  pcpa_pkg::status_t    fin_status;
  logic [PGW-1:0]       fin_page;

  function automatic logic [CW-1:0] next_cpu(input logic [CW-1:0] x);
    logic [CW-1:0] r;
    if (x == LAST_CPU) begin
      r = '0;
    end else begin
      r = x + 1'b1;
    end
    return r;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign hd        = hrd_vld_r ? head_rdata : END_MARK;

  always_comb begin
    logic [CFW-1:0] cm;
    cm = in_cpu;
    for (int j = 0; j < (1 << CFW); j++) begin
      if (int'(cm) >= NUM_CPUS) begin
        cm = cm - CFW'(NUM_CPUS);
      end
    end
    cmod = CW'(cm);
  end

  assign bad_page = (in_page < cfg.lowest_page) ||
                    ({1'b0, in_page} >= cfg.page_limit) ||
                    (int'(in_page) >= NUM_PAGES);

  always_comb begin
    state_nxt  = state_r;
    c_nxt      = c_r;
    pg_nxt     = pg_r;
    v_nxt      = v_r;
    left_nxt   = left_r;
    h_nxt      = h_r;
    lh_nxt     = lh_r;
    last_nxt   = last_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    head_we    = 1'b0;
    head_waddr = c_r;
    head_wdata = h_r;
    head_re    = 1'b0;
    head_raddr = c_r;
    link_we    = 1'b0;
    link_waddr = AW'(last_r);
    link_wdata = END_MARK;
    link_re    = 1'b0;
    link_raddr = AW'(h_r);
    fin        = 1'b0;
    fin_status = pcpa_pkg::ST_OOM;
    fin_page   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          c_nxt  = cmod;
          pg_nxt = in_page;
          if (in_command == pcpa_pkg::CMD_FREE && bad_page) begin
            fin        = 1'b1;
            fin_status = pcpa_pkg::ST_BAD;
          end else begin
            head_re    = 1'b1;
            head_raddr = cmod;
            state_nxt  = (in_command == pcpa_pkg::CMD_FREE) ? S_FREE : S_AHEAD;
          end
        end
      end
      S_FREE: begin
        link_we    = 1'b1;
        link_waddr = AW'(pg_r);
        link_wdata = hd;
        head_we    = 1'b1;
        head_waddr = c_r;
        head_wdata = PW'(pg_r);
        fin        = 1'b1;
        fin_status = pcpa_pkg::ST_FREED;
      end
      S_AHEAD: begin
        if (hd != END_MARK) begin
          h_nxt      = hd;
          link_re    = 1'b1;
          link_raddr = AW'(hd);
          state_nxt  = S_APOP;
        end else if (NUM_CPUS == 1) begin
          fin        = 1'b1;
          fin_status = pcpa_pkg::ST_OOM;
        end else begin
          v_nxt      = next_cpu(c_r);
          left_nxt   = LAST_CPU;
          head_re    = 1'b1;
          head_raddr = next_cpu(c_r);
          state_nxt  = S_SCAN;
        end
      end
      S_APOP: begin
        head_we    = 1'b1;
        head_waddr = c_r;
        head_wdata = link_rdata;
        fin        = 1'b1;
        fin_status = pcpa_pkg::ST_ALLOC;
        fin_page   = PGW'(h_r);
      end
      S_SCAN: begin
        if (hd != END_MARK) begin
          h_nxt      = hd;
          n_nxt      = PW'(1);
          link_re    = 1'b1;
          link_raddr = AW'(hd);
          state_nxt  = S_CNT;
        end else if (left_r == CW'(1)) begin
          fin        = 1'b1;
          fin_status = pcpa_pkg::ST_OOM;
        end else begin
          left_nxt   = left_r - 1'b1;
          v_nxt      = next_cpu(v_r);
          head_re    = 1'b1;
          head_raddr = next_cpu(v_r);
        end
      end
      S_CNT: begin
        if (n_r == PW'(1)) begin
          lh_nxt = link_rdata;
        end
        if (link_rdata == END_MARK || n_r == END_MARK) begin
          k_nxt      = PW'(({1'b0, n_r} + (PW + 1)'(1)) >> 1);
          last_nxt   = h_r;
          link_re    = 1'b1;
          link_raddr = AW'(h_r);
          state_nxt  = S_WALK;
        end else begin
          n_nxt      = n_r + 1'b1;
          link_re    = 1'b1;
          link_raddr = AW'(link_rdata);
        end
      end
      S_WALK: begin
        if (k_r > PW'(1)) begin
          last_nxt   = link_rdata;
          k_nxt      = k_r - 1'b1;
          link_re    = 1'b1;
          link_raddr = AW'(link_rdata);
        end else begin
          head_we    = 1'b1;
          head_waddr = v_r;
          head_wdata = link_rdata;
          link_we    = 1'b1;
          link_waddr = AW'(last_r);
          link_wdata = END_MARK;
          state_nxt  = S_GIVE;
        end
      end
      S_GIVE: begin
        head_we    = 1'b1;
        head_waddr = c_r;
        head_wdata = (last_r == h_r) ? END_MARK : lh_r;
        fin        = 1'b1;
        fin_status = pcpa_pkg::ST_ALLOC;
        fin_page   = PGW'(h_r);
      end
      S_WAIT: ;
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;

    if (fin) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = fin_status;
        out_page_nxt   = fin_page;
        state_nxt      = S_IDLE;
      end else begin
        res_status_nxt = fin_status;
        res_page_nxt   = fin_page;
        state_nxt      = S_WAIT;
      end
    end else if (state_r == S_WAIT && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_page_nxt   = res_page_r;
      state_nxt      = S_IDLE;
    end
  end

  always_comb begin
    hvld_nxt = hvld_r;
    if (head_we) begin
      hvld_nxt[head_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hvld_r      <= hvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r          <= c_nxt;
    pg_r         <= pg_nxt;
    v_r          <= v_nxt;
    left_r       <= left_nxt;
    h_r          <= h_nxt;
    lh_r         <= lh_nxt;
    last_r       <= last_nxt;
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    if (head_re) begin
      hrd_vld_r <= hvld_r[head_raddr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_page = out_page_r;

  a_link_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    (link_we && link_re) |-> (link_waddr != link_raddr))
    else $error("link read and write to the same entry in one cycle");

  a_head_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    (head_we && head_re) |-> (head_waddr != head_raddr))
    else $error("head read and write to the same entry in one cycle");

  a_grant_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && fin_status == pcpa_pkg::ST_ALLOC) |-> (h_r != END_MARK))
    else $error("grant of the end marker");

  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (k_r != '0))
    else $error("split walk with zero count");

  a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (left_r != '0))
    else $error("victim scan past the last CPU");

endmodule
`default_nettype wire

@@ sv/per_cpu_page_allocator_steal.sv @@
// Top level of the per-CPU page allocator with work stealing.
//
//  Port group | Direction | Handshake          | Beat contents
//  in_*       | input     | in_valid/in_stall  | command, cpu, page
//  out_*      | output    | out_valid/out_stall| status, granted_page
//  cfg_*      | input     | APB write/read     | lowest_page (0x0), page_limit (0x4)
//
// Bad free: answered from idle. Good free: head read, then link and head write.
// Own alloc: head read, link read, head write. Steal: scan, count, split walk;
// the single read port of the link memory paces the list walk.
// Reset clears every list head at once; the link memory needs no clearing.
// A stalled result sits in the output register; one more finished result is
// held internally, after which the input stalls.
`default_nettype none
module per_cpu_page_allocator_steal #(
  parameter int NUM_CPUS  = pcpa_pkg::DEF_NUM_CPUS,
  parameter int NUM_PAGES = pcpa_pkg::DEF_NUM_PAGES
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_command,
  input  wire logic [pcpa_pkg::CPU_W-1:0]          in_cpu,
  input  wire logic [pcpa_pkg::PAGE_W-1:0]         in_page,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [pcpa_pkg::STATUS_W-1:0]       out_status,
  output logic      [pcpa_pkg::PAGE_W-1:0]         out_granted_page,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [pcpa_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [pcpa_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic      [pcpa_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int AW = $clog2(NUM_PAGES);
  localparam int PW = $clog2(NUM_PAGES + 1);

  pcpa_pkg::cfg_regs_t cfg_regs;

  logic          head_we;
  logic [CW-1:0] head_waddr;
  logic [PW-1:0] head_wdata;
  logic          head_re;
  logic [CW-1:0] head_raddr;
  logic [PW-1:0] head_rdata;
  logic          link_we;
  logic [AW-1:0] link_waddr;
  logic [PW-1:0] link_wdata;
  logic          link_re;
  logic [AW-1:0] link_raddr;
  logic [PW-1:0] link_rdata;

  pcpa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .regs        (cfg_regs)
  );

  pcpa_ram #(
    .DEPTH (NUM_CPUS),
    .WIDTH (PW),
    .AW    (CW)
  ) u_head_mem (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (head_re),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  pcpa_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (PW),
    .AW    (AW)
  ) u_link_mem (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  pcpa_seq #(
    .NUM_CPUS  (NUM_CPUS),
    .NUM_PAGES (NUM_PAGES),
    .CW        (CW),
    .AW        (AW),
    .PW        (PW)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_regs),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_cpu           (in_cpu),
    .in_page          (in_page),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_granted_page (out_granted_page),
    .head_we          (head_we),
    .head_waddr       (head_waddr),
    .head_wdata       (head_wdata),
    .head_re          (head_re),
    .head_raddr       (head_raddr),
    .head_rdata       (head_rdata),
    .link_we          (link_we),
    .link_waddr       (link_waddr),
    .link_wdata       (link_wdata),
    .link_re          (link_re),
    .link_raddr       (link_raddr),
    .link_rdata       (link_rdata)
  );

endmodule
`default_nettype wire
